// ----- src/lfpr_pkg.sv -----
// Shared types and constants for the length-framed packet receiver.
package lfpr_pkg;

  localparam logic [7:0] HEADER_BYTE       = 8'hFD;
  localparam int         DEFAULT_BUF_DEPTH = 128;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LENGTH = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  typedef struct packed {
    logic       store_valid;
    logic [6:0] store_index;
    logic [7:0] store_data;
    logic       payload_overflow;
    logic       frame_end;
    logic       frame_good;
    logic       frame_abort;
  } result_t;

endpackage

// ----- src/lfpr_core.sv -----
// Frame parser state and per-beat next-state and result logic.
module lfpr_core #(
  parameter int BUF_DEPTH = lfpr_pkg::DEFAULT_BUF_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       rx_byte,
  output lfpr_pkg::result_t result
);
  import lfpr_pkg::*;

  localparam logic [16:0] DEPTH = 17'(BUF_DEPTH);

  phase_t      phase, phase_next;
  logic        length_low_next, length_low_next_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      length_low_next <= 1'b0;
      payload_length  <= '0;
      byte_count      <= '0;
      running_sum     <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      length_low_next <= length_low_next_next;
      payload_length  <= payload_length_next;
      byte_count      <= byte_count_next;
      running_sum     <= running_sum_next;
    end
  end

  assign count_inc = byte_count + 16'd1;

  always_comb begin
    phase_next           = phase;
    length_low_next_next = length_low_next;
    payload_length_next  = payload_length;
    byte_count_next      = byte_count;
    running_sum_next     = running_sum;
    result               = '0;
    unique case (phase)
      PH_TYPE: begin
        if (rx_byte != 8'd0) begin
          phase_next           = PH_LENGTH;
          length_low_next_next = 1'b0;
        end else begin
          result.frame_abort   = 1'b1;
          phase_next           = PH_HEADER;
          length_low_next_next = 1'b0;
          payload_length_next  = '0;
          byte_count_next      = '0;
          running_sum_next     = '0;
        end
      end
      PH_LENGTH: begin
        running_sum_next = running_sum + rx_byte;
        if (!length_low_next) begin
          payload_length_next  = {rx_byte, 8'd0};
          length_low_next_next = 1'b1;
        end else begin
          payload_length_next  = payload_length | {8'd0, rx_byte};
          length_low_next_next = 1'b0;
          byte_count_next      = '0;
          phase_next           = PH_DATA;
        end
      end
      PH_DATA: begin
        if (payload_length == 16'd0 || byte_count >= payload_length) begin
          result.frame_abort   = 1'b1;
          phase_next           = PH_HEADER;
          length_low_next_next = 1'b0;
          payload_length_next  = '0;
          byte_count_next      = '0;
          running_sum_next     = '0;
        end else begin
          running_sum_next = running_sum + rx_byte;
          if ({1'b0, byte_count} < DEPTH) begin
            result.store_valid = 1'b1;
            result.store_index = byte_count[6:0];
            result.store_data  = rx_byte;
          end else begin
            result.payload_overflow = 1'b1;
          end
          byte_count_next = count_inc;
          if (count_inc == payload_length) begin
            phase_next = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        result.frame_end     = 1'b1;
        result.frame_good    = (rx_byte == running_sum);
        phase_next           = PH_HEADER;
        length_low_next_next = 1'b0;
        payload_length_next  = '0;
        byte_count_next      = '0;
        running_sum_next     = '0;
      end
      default: begin
        length_low_next_next = 1'b0;
        payload_length_next  = '0;
        byte_count_next      = '0;
        running_sum_next     = '0;
        phase_next           = (rx_byte == HEADER_BYTE) ? PH_TYPE : PH_HEADER;
      end
    endcase
  end

endmodule

// ----- src/length_framed_packet_receiver.sv -----
// Length-framed packet receiver: one result beat per received byte.
// Parses frames of a 0xFD header, a non-zero type byte, a 16-bit big-endian
// length, the payload and an 8-bit checksum (sum of both length bytes and all
// payload bytes). Every accepted byte yields exactly one registered result
// beat; a byte can be accepted every cycle while the result register is empty
// or being drained, so throughput is one byte per clock. Payload bytes at
// positions below BUF_DEPTH come out as buffer writes; later ones are flagged
// as overflow. Zero type or zero length drops the frame with frame_abort.
module length_framed_packet_receiver #(
  parameter int BUF_DEPTH = lfpr_pkg::DEFAULT_BUF_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       store_valid,
  output logic [6:0] store_index,
  output logic [7:0] store_data,
  output logic       payload_overflow,
  output logic       frame_end,
  output logic       frame_good,
  output logic       frame_abort
);
  import lfpr_pkg::*;

  logic    accept;
  result_t step_result;
  result_t result;

  assign rx_ready = !res_valid || res_ready;
  assign accept   = rx_valid && rx_ready;

  lfpr_core #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .advance(accept),
    .rx_byte(rx_byte),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= step_result;
    end
  end

  assign store_valid      = result.store_valid;
  assign store_index      = result.store_index;
  assign store_data       = result.store_data;
  assign payload_overflow = result.payload_overflow;
  assign frame_end        = result.frame_end;
  assign frame_good       = result.frame_good;
  assign frame_abort      = result.frame_abort;

  a_beat_yields_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted byte produced no result beat");

  a_good_needs_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_good |-> frame_end)
    else $error("frame_good without frame_end");

  a_single_event: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({store_valid, payload_overflow, frame_end, frame_abort}))
    else $error("more than one event flagged in one beat");

endmodule
